>>> rtl/prqg_pkg.sv
// Package with the constants, codes and shared types of the quota grant block.
`timescale 1ns / 1ps
`default_nettype none
package prqg_pkg;

  localparam int CORES       = 8;
  localparam int RESOURCES   = 128;
  localparam int MASK_W      = 8;
  localparam int RESOURCE_W  = 7;
  localparam int QUOTA_W     = 32;
  localparam int TIME_W      = 32;
  localparam int COUNT_W     = 4;
  localparam int INTERVAL_W  = 16;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 32;
  localparam int RES_IDX_W   = $clog2(RESOURCES);
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // Only the lower cores that fit in the mask take part.
  localparam int ACTIVE_CORES = (CORES < MASK_W) ? CORES : MASK_W;

  localparam logic [QUOTA_W-1:0]    START_QUOTA     = QUOTA_W'(1000);
  localparam logic [TIME_W-1:0]     START_TIME      = '0;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET  = INTERVAL_W'(100);

  localparam logic KIND_SCAN   = 1'b0;
  localparam logic KIND_REFILL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_REPORT_INTERVAL = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_ENABLE   = CFG_IDX_W'(1);

  typedef struct packed {
    logic [INTERVAL_W-1:0] report_interval;
    logic                  report_enable;
  } cfg_t;

  // One classified item waiting for the back end.
  typedef struct packed {
    logic                 kind;
    logic                 in_range;
    logic [RES_IDX_W-1:0] idx;
    logic [MASK_W-1:0]    req;
    logic [QUOTA_W-1:0]   new_quota;
    logic [TIME_W-1:0]    now;
  } entry_t;

endpackage
`default_nettype wire

>>> rtl/prqg_if.sv
// Channel interfaces of the quota grant block: items in, results out, register writes.
`timescale 1ns / 1ps
`default_nettype none
interface prqg_in_if;
  import prqg_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [RESOURCE_W-1:0] resource;
  logic [MASK_W-1:0]     request_mask;
  logic [QUOTA_W-1:0]    new_quota;
  logic [TIME_W-1:0]     now;
  modport source (output valid, kind, resource, request_mask, new_quota, now, input ready);
  modport sink   (input valid, kind, resource, request_mask, new_quota, now, output ready);
endinterface

interface prqg_out_if;
  import prqg_pkg::*;
  logic               valid;
  logic               ready;
  logic [MASK_W-1:0]  grant_mask;
  logic [MASK_W-1:0]  deny_mask;
  logic [COUNT_W-1:0] granted_count;
  logic [QUOTA_W-1:0] remaining_quota;
  logic               report;
  modport source (output valid, grant_mask, deny_mask, granted_count, remaining_quota, report,
                  input ready);
  modport sink   (input valid, grant_mask, deny_mask, granted_count, remaining_quota, report,
                  output ready);
endinterface

interface prqg_cfg_if;
  import prqg_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/prqg_front.sv
// Front end: accepts items, masks the request bits and sorts out what the back end must do.
`timescale 1ns / 1ps
`default_nettype none
module prqg_front import prqg_pkg::*; (
  prqg_in_if.sink       in_ch,
  input  logic          full,
  output logic          push,
  output entry_t        entry
);

  logic [MASK_W-1:0] core_mask;
  logic              in_range;
  logic              accept;

  always_comb begin
    core_mask = '0;
    for (int c = 0; c < MASK_W; c++) begin
      if (c < ACTIVE_CORES) begin
        core_mask[c] = 1'b1;
      end
    end
  end

  assign in_range = (32'(in_ch.resource) < 32'(RESOURCES));
  assign in_ch.ready = !full;
  assign accept = in_ch.valid && !full;

  // A refill of a resource that does not exist is dropped here.
  assign push = accept && !((in_ch.kind == KIND_REFILL) && !in_range);

  always_comb begin
    entry.kind      = in_ch.kind;
    entry.in_range  = in_range;
    entry.idx       = RES_IDX_W'(in_ch.resource);
    entry.req       = in_ch.request_mask & core_mask;
    entry.new_quota = in_ch.new_quota;
    entry.now       = in_ch.now;
  end

endmodule
`default_nettype wire

>>> rtl/prqg_fifo.sv
// Short queue of classified items between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module prqg_fifo import prqg_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   full,
  output logic   empty
);

  entry_t                 slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;

  assign full  = (count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/prqg_back.sv
// Back end: quota and report-time tables, grant selection and the result register.
`timescale 1ns / 1ps
`default_nettype none
module prqg_back import prqg_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  q_empty,
  input  entry_t q_head,
  output logic  q_pop,
  prqg_out_if.source out_ch
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;
  entry_t cmd;

  logic [QUOTA_W-1:0]   quota_mem [RESOURCES];
  logic [TIME_W-1:0]    time_mem  [RESOURCES];
  logic [RESOURCES-1:0] quota_written;
  logic [RESOURCES-1:0] time_written;

  logic [QUOTA_W-1:0] quota_rd;
  logic [TIME_W-1:0]  time_rd;
  logic               quota_rd_written;
  logic               time_rd_written;
  logic               quota_byp;
  logic               time_byp;
  logic [QUOTA_W-1:0] quota_byp_data;
  logic [TIME_W-1:0]  time_byp_data;

  logic [QUOTA_W-1:0] quota_cur;
  logic [TIME_W-1:0]  time_cur;
  logic [COUNT_W-1:0] limit;
  logic [COUNT_W-1:0] count;
  logic [MASK_W-1:0]  grant;
  logic [MASK_W-1:0]  deny;
  logic [QUOTA_W-1:0] remaining;
  logic [TIME_W-1:0]  elapsed;
  logic               interval_due;

  logic out_free;
  logic fire;
  logic wq_en;
  logic wt_en;
  logic [QUOTA_W-1:0] wq_data;

  assign out_free = !out_ch.valid || out_ch.ready;
  assign fire = (state == ST_EXEC) && ((cmd.kind == KIND_REFILL) || out_free);
  assign q_pop = ((state == ST_IDLE) || fire) && !q_empty;

  always_comb begin
    case (state)
      ST_IDLE: state_next = q_pop ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_next = q_pop ? ST_EXEC : (fire ? ST_IDLE : ST_EXEC);
      default: state_next = ST_IDLE;
    endcase
  end

  // Entries never written read as their reset value; a write in the cycle
  // of the following read is forwarded.
  assign quota_cur = quota_byp ? quota_byp_data : (quota_rd_written ? quota_rd : START_QUOTA);
  assign time_cur  = time_byp ? time_byp_data : (time_rd_written ? time_rd : START_TIME);

  assign limit = (quota_cur >= QUOTA_W'(ACTIVE_CORES)) ? COUNT_W'(ACTIVE_CORES)
                                                     : COUNT_W'(quota_cur);

  // Highest-numbered requester first, until the quota runs out.
  always_comb begin
    grant = '0;
    deny  = '0;
    count = '0;
    for (int c = MASK_W - 1; c >= 0; c--) begin
      if (cmd.req[c]) begin
        if (count < limit) begin
          grant[c] = 1'b1;
          count    = count + 1'b1;
        end else begin
          deny[c] = 1'b1;
        end
      end
    end
  end

  assign remaining    = quota_cur - QUOTA_W'(count);
  assign elapsed      = cmd.now - time_cur;
  assign interval_due = (elapsed > TIME_W'(cfg.report_interval));

  assign wq_en   = fire && cmd.in_range;
  assign wq_data = (cmd.kind == KIND_REFILL) ? cmd.new_quota : remaining;
  assign wt_en   = fire && cmd.in_range && (cmd.kind == KIND_SCAN) && interval_due;

  always_ff @(posedge clk) begin
    if (wq_en) begin
      quota_mem[cmd.idx] <= wq_data;
    end
    if (wt_en) begin
      time_mem[cmd.idx] <= cmd.now;
    end
    if (q_pop) begin
      quota_rd <= quota_mem[q_head.idx];
      time_rd  <= time_mem[q_head.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd              <= q_head;
      quota_rd_written <= quota_written[q_head.idx];
      time_rd_written  <= time_written[q_head.idx];
      quota_byp        <= wq_en && (cmd.idx == q_head.idx);
      time_byp         <= wt_en && (cmd.idx == q_head.idx);
      quota_byp_data   <= wq_data;
      time_byp_data    <= cmd.now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      quota_written <= '0;
      time_written  <= '0;
    end else begin
      state <= state_next;
      if (wq_en) begin
        quota_written[cmd.idx] <= 1'b1;
      end
      if (wt_en) begin
        time_written[cmd.idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (fire && (cmd.kind == KIND_SCAN)) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && (cmd.kind == KIND_SCAN)) begin
      if (cmd.in_range) begin
        out_ch.grant_mask      <= grant;
        out_ch.deny_mask       <= deny;
        out_ch.granted_count   <= count;
        out_ch.remaining_quota <= remaining;
        out_ch.report          <= interval_due && cfg.report_enable;
      end else begin
        out_ch.grant_mask      <= '0;
        out_ch.deny_mask       <= cmd.req;
        out_ch.granted_count   <= '0;
        out_ch.remaining_quota <= '0;
        out_ch.report          <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/per_resource_quota_grant.sv
// Top level of the per-resource quota grant block.
//
//   Channel  Direction  Handshake      Carries
//   in_ch    in         valid/ready    kind, resource, request_mask, new_quota, now
//   out_ch   out        valid/ready    grant_mask, deny_mask, granted_count,
//                                      remaining_quota, report
//   cfg_ch   in         valid/ready    index, data (report_interval, report_enable)
//
// Each item is handled in overlapped back-end steps, a table read then grant selection
// and write-back, so one item finishes per cycle while no scan is stalled; a scan's
// result passes a queue slot and the command and result registers. A two-entry queue
// takes one input item per cycle while it has room. A result that is not taken stalls
// the back end at the next scan; refills go on. Reset clears control state only; table
// entries read as their reset values until written. cfg_ch writes are always taken.
`timescale 1ns / 1ps
`default_nettype none
module per_resource_quota_grant import prqg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  prqg_in_if.sink     in_ch,
  prqg_out_if.source  out_ch,
  prqg_cfg_if.sink    cfg_ch
);

  cfg_t   cfg;
  logic   push;
  logic   pop;
  logic   full;
  logic   empty;
  entry_t push_entry;
  entry_t head;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.report_interval <= INTERVAL_RESET;
      cfg.report_enable   <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_REPORT_INTERVAL: cfg.report_interval <= cfg_ch.data[INTERVAL_W-1:0];
        REG_REPORT_ENABLE:   cfg.report_enable   <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  prqg_front u_front (
    .in_ch (in_ch),
    .full  (full),
    .push  (push),
    .entry (push_entry)
  );

  prqg_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (full),
    .empty      (empty)
  );

  prqg_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (empty),
    .q_head  (head),
    .q_pop   (pop),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

>>> rtl/prqg_checker.sv
// Port-level checks on the quota grant block and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none
module prqg_checker import prqg_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [MASK_W-1:0]  grant_mask,
  input logic [MASK_W-1:0]  deny_mask,
  input logic [COUNT_W-1:0] granted_count
);

  // A result waiting to be taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered right after reset");

  // A core is never both granted and denied.
  a_disjoint: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((grant_mask & deny_mask) == '0))
    else $error("core both granted and denied");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(granted_count) == $countones(grant_mask)))
    else $error("granted count does not match grant mask");

endmodule

bind per_resource_quota_grant prqg_checker u_prqg_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .grant_mask    (out_ch.grant_mask),
  .deny_mask     (out_ch.deny_mask),
  .granted_count (out_ch.granted_count)
);
`default_nettype wire
